FILE: rtl/canonical_huffman_decoder_core_defines.svh
// Assertion macros used by the checker of the Huffman decoder core.
`ifndef CANONICAL_HUFFMAN_DECODER_CORE_DEFINES_SVH
`define CANONICAL_HUFFMAN_DECODER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CHD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CHD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/chd_pkg.sv
// Types and constants of the canonical Huffman decoder.
package chd_pkg;

   localparam int SYMBOL_W    = 8;
   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 8;
   localparam int LENGTH_W    = 16;
   localparam int CODE_W      = 16;
   localparam int BITS_LEFT_W = 4;
   localparam int BYTE_BITS   = 8;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_COUNT  = 2'd1,
      ACT_SYMBOL = 2'd2,
      ACT_DATA   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIT,
      ST_SYM,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
      logic                frame_done;
      logic                code_error;
   } result_type;

endpackage

FILE: rtl/chd_channels.sv
// Valid/ready channel interfaces for the decoder's request and response beats.
interface chd_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [chd_pkg::INDEX_W-1:0]   table_index;
   logic [chd_pkg::SYMBOL_W-1:0]  byte_value;
   logic [chd_pkg::LENGTH_W-1:0]  frame_length;

   modport source (output valid, action, table_index, byte_value, frame_length,
                   input ready);
   modport sink (input valid, action, table_index, byte_value, frame_length,
                 output ready);
endinterface

interface chd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [chd_pkg::SYMBOL_W-1:0]  symbol;
   logic                          last;
   logic                          frame_done;
   logic                          code_error;

   modport source (output valid, symbol, last, frame_done, code_error, input ready);
   modport sink (input valid, symbol, last, frame_done, code_error, output ready);
endinterface

FILE: rtl/canonical_huffman_decoder_core.sv
// Canonical Huffman decoder core: bit-serial decode of a byte stream into symbols.
//
// req_if carries one action per beat: start frame (sets the symbol count and
// clears the partial code), load a code-length count, load a sorted symbol
// entry, or a data byte. rsp_if returns decoded symbols; last marks the final
// beat caused by one data byte, frame_done the symbol that ends the frame,
// code_error a code longer than MAX_CODE_LEN (symbol then 0).
// Start and load beats complete in ST_IDLE. A raw-mode byte (count entry 0
// nonzero) goes through ST_FLUSH. A coded byte is shifted through ST_BIT one
// code bit at a time, up to 8, visits ST_SYM per decoded symbol for the symbol
// memory's registered read, and ends in ST_FLUSH, which moves the final beat out.
// Decode stops early once the frame count reaches zero.
// req_if.ready is high only between bytes. One decoded beat is held back until
// the next one or the end of the byte shows whether it is the last; decoding
// stalls while that beat and the output register are both full and rsp_if
// is not ready.
// Reset clears the count table, the partial code, the frame count and the output
// valid flags; the symbol memory holds garbage until loaded.
module canonical_huffman_decoder_core #(
   parameter int MAX_CODE_LEN = 16,
   parameter int SYMBOL_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   chd_req_if.sink       req_if,
   chd_rsp_if.source     rsp_if
);

   localparam int AW  = $clog2(SYMBOL_DEPTH);
   localparam int CLW = $clog2(MAX_CODE_LEN + 1);
   localparam logic [AW:0]  DEPTH_L = (AW+1)'(SYMBOL_DEPTH);
   localparam logic [CLW-1:0] MAX_LEN_L = CLW'(MAX_CODE_LEN);

   typedef logic [AW-1:0] mod_tbl_type [256];

   // Residue of every byte value modulo the symbol depth.
   function automatic mod_tbl_type build_mod_tbl();
      mod_tbl_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = AW'(i % SYMBOL_DEPTH);
      end
      return t;
   endfunction

   localparam mod_tbl_type MOD_TBL = build_mod_tbl();

   chd_pkg::state_type                state_ff, state_in;
   logic [chd_pkg::COUNT_W-1:0]       counts_ff [MAX_CODE_LEN+1];
   logic [chd_pkg::COUNT_W-1:0]       counts_in [MAX_CODE_LEN+1];
   logic [chd_pkg::CODE_W-1:0]        code_accum_ff, code_accum_in;
   logic [chd_pkg::CODE_W-1:0]        row_first_code_ff, row_first_code_in;
   logic [AW-1:0]                     row_first_index_ff, row_first_index_in;
   logic [CLW-1:0]                    code_len_ff, code_len_in;
   logic [chd_pkg::LENGTH_W-1:0]      symbols_left_ff, symbols_left_in;
   logic [chd_pkg::BITS_LEFT_W-1:0]   bits_left_ff, bits_left_in;
   logic                              sym_done_ff, sym_done_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic                              out_valid_ff, out_valid_in;
   logic [chd_pkg::SYMBOL_W-1:0]      shift_ff, shift_in;
   chd_pkg::result_type               pend_ff, pend_in;
   chd_pkg::result_type               out_ff, out_in;

   logic [chd_pkg::SYMBOL_W-1:0]      sym_mem [SYMBOL_DEPTH];
   logic [chd_pkg::SYMBOL_W-1:0]      sym_rd_ff;
   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic                              rd_en;

   logic                              out_free;
   logic                              hold;
   logic                              gen;
   chd_pkg::result_type               gen_res;
   logic [chd_pkg::CODE_W-1:0]        acc_next;
   logic [chd_pkg::CODE_W-1:0]        rfc_shift;
   logic [chd_pkg::CODE_W-1:0]        diff;
   logic [chd_pkg::COUNT_W-1:0]       cnt;
   logic                              match;
   logic [AW:0]                       idx_sum;
   logic [AW-1:0]                     idx;
   logic [AW:0]                       rfi_sum;
   logic [chd_pkg::LENGTH_W-1:0]      left_dec;

   // One code bit per cycle while not held, lsb of the byte first.
   always_comb begin
      acc_next  = {code_accum_ff[chd_pkg::CODE_W-2:0], shift_ff[0]};
      rfc_shift = {row_first_code_ff[chd_pkg::CODE_W-2:0], 1'b0};
      cnt       = counts_ff[code_len_ff];
      diff      = acc_next - rfc_shift;
      match     = (acc_next >= rfc_shift) && (diff[chd_pkg::CODE_W-1:8] == '0) &&
                  (diff[7:0] < cnt);
      idx_sum   = {1'b0, MOD_TBL[diff[7:0]]} + {1'b0, row_first_index_ff};
      idx       = (idx_sum >= DEPTH_L) ? AW'(idx_sum - DEPTH_L) : idx_sum[AW-1:0];
      rfi_sum   = {1'b0, MOD_TBL[cnt]} + {1'b0, row_first_index_ff};
      left_dec  = symbols_left_ff - 16'd1;
   end

   always_comb begin
      state_in           = state_ff;
      counts_in          = counts_ff;
      code_accum_in      = code_accum_ff;
      row_first_code_in  = row_first_code_ff;
      row_first_index_in = row_first_index_ff;
      code_len_in        = code_len_ff;
      symbols_left_in    = symbols_left_ff;
      bits_left_in       = bits_left_ff;
      sym_done_in        = sym_done_ff;
      pend_valid_in      = pend_valid_ff;
      pend_in            = pend_ff;
      out_valid_in       = out_valid_ff;
      out_in             = out_ff;
      shift_in           = shift_ff;
      mem_we             = 1'b0;
      mem_waddr          = MOD_TBL[req_if.table_index];
      rd_en              = 1'b0;
      gen                = 1'b0;
      gen_res            = '0;

      out_free = !out_valid_ff || rsp_if.ready;
      hold     = pend_valid_ff && !out_free;
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         chd_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               case (chd_pkg::action_type'(req_if.action))
                  chd_pkg::ACT_START: begin
                     symbols_left_in    = req_if.frame_length;
                     code_accum_in      = '0;
                     row_first_code_in  = '0;
                     row_first_index_in = '0;
                     code_len_in        = CLW'(1);
                  end
                  chd_pkg::ACT_COUNT: begin
                     if (req_if.table_index <= 8'(MAX_CODE_LEN)) begin
                        counts_in[req_if.table_index[CLW-1:0]] = req_if.byte_value;
                     end
                  end
                  chd_pkg::ACT_SYMBOL: begin
                     mem_we = 1'b1;
                  end
                  chd_pkg::ACT_DATA: begin
                     if (symbols_left_ff != '0) begin
                        if (counts_ff[0] != '0) begin
                           gen                = 1'b1;
                           gen_res.symbol     = req_if.byte_value;
                           gen_res.frame_done = (left_dec == '0);
                           symbols_left_in    = left_dec;
                           state_in           = chd_pkg::ST_FLUSH;
                        end else begin
                           shift_in     = req_if.byte_value;
                           bits_left_in = chd_pkg::BITS_LEFT_W'(chd_pkg::BYTE_BITS);
                           state_in     = chd_pkg::ST_BIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         chd_pkg::ST_BIT: begin
            if (!hold) begin
               shift_in     = shift_ff >> 1;
               bits_left_in = bits_left_ff - 4'd1;
               if (match) begin
                  rd_en              = 1'b1;
                  symbols_left_in    = left_dec;
                  sym_done_in        = (left_dec == '0);
                  code_accum_in      = '0;
                  row_first_code_in  = '0;
                  row_first_index_in = '0;
                  code_len_in        = CLW'(1);
                  state_in           = chd_pkg::ST_SYM;
               end else begin
                  code_accum_in      = acc_next;
                  row_first_code_in  = rfc_shift + {8'b0, cnt};
                  row_first_index_in = (rfi_sum >= DEPTH_L) ? AW'(rfi_sum - DEPTH_L)
                                                            : rfi_sum[AW-1:0];
                  code_len_in        = code_len_ff + CLW'(1);
                  if (code_len_ff == MAX_LEN_L) begin
                     // code too long: flag it and start over at the next bit
                     gen                = 1'b1;
                     gen_res.code_error = 1'b1;
                     code_accum_in      = '0;
                     row_first_code_in  = '0;
                     row_first_index_in = '0;
                     code_len_in        = CLW'(1);
                  end
                  state_in = (bits_left_ff == 4'd1) ? chd_pkg::ST_FLUSH : chd_pkg::ST_BIT;
               end
            end
         end
         chd_pkg::ST_SYM: begin
            if (!hold) begin
               gen                = 1'b1;
               gen_res.symbol     = sym_rd_ff;
               gen_res.frame_done = sym_done_ff;
               state_in = (sym_done_ff || bits_left_ff == '0) ? chd_pkg::ST_FLUSH
                                                             : chd_pkg::ST_BIT;
            end
         end
         chd_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = chd_pkg::ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = chd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chd_pkg::ST_IDLE;
         end
      endcase

      // A new beat pushes the held one out; it was not the last of its byte.
      if (gen) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_in.last  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = gen_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= chd_pkg::ST_IDLE;
         counts_ff          <= '{default: '0};
         code_accum_ff      <= '0;
         row_first_code_ff  <= '0;
         row_first_index_ff <= '0;
         code_len_ff        <= CLW'(1);
         symbols_left_ff    <= '0;
         bits_left_ff       <= '0;
         sym_done_ff        <= 1'b0;
         pend_valid_ff      <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         counts_ff          <= counts_in;
         code_accum_ff      <= code_accum_in;
         row_first_code_ff  <= row_first_code_in;
         row_first_index_ff <= row_first_index_in;
         code_len_ff        <= code_len_in;
         symbols_left_ff    <= symbols_left_in;
         bits_left_ff       <= bits_left_in;
         sym_done_ff        <= sym_done_in;
         pend_valid_ff      <= pend_valid_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sym_mem[mem_waddr] <= req_if.byte_value;
      end
      if (rd_en) begin
         sym_rd_ff <= sym_mem[idx];
      end
   end

   assign req_if.ready      = (state_ff == chd_pkg::ST_IDLE);
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.symbol     = out_ff.symbol;
   assign rsp_if.last       = out_ff.last;
   assign rsp_if.frame_done = out_ff.frame_done;
   assign rsp_if.code_error = out_ff.code_error;

endmodule

FILE: rtl/chd_checker.sv
// Port-level checks of the Huffman decoder core, bound into the core module.
`include "canonical_huffman_decoder_core_defines.svh"

module chd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [chd_pkg::SYMBOL_W-1:0] rsp_symbol,
   input logic                         rsp_last,
   input logic                         rsp_frame_done,
   input logic                         rsp_code_error
);

   `CHD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")
   `CHD_ASSERT(a_err_clean, rsp_valid && rsp_code_error |-> rsp_symbol == '0 && !rsp_frame_done, "error beat carries data")
   `CHD_ASSERT(a_done_last, rsp_valid && rsp_frame_done |-> rsp_last, "frame end not last of its byte")
   `CHD_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind canonical_huffman_decoder_core chd_checker u_chd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_symbol     (rsp_if.symbol),
   .rsp_last       (rsp_if.last),
   .rsp_frame_done (rsp_if.frame_done),
   .rsp_code_error (rsp_if.code_error)
);

FILE: verif/canonical_huffman_decoder_core_tb.sv
// Self-checking testbench for the canonical Huffman decoder core: directed and random beats.
module canonical_huffman_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import chd_pkg::*;

   typedef struct {
      action_type          act;
      logic [INDEX_W-1:0]  tidx;
      logic [SYMBOL_W-1:0] bval;
      logic [LENGTH_W-1:0] flen;
      int                  phase;
      bit                  hold;
   } huff_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chd_req_if req_ch ();
   chd_rsp_if rsp_ch ();

   canonical_huffman_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle percentages per phase: none, sender, receiver, both
   int sender_idle_pct [4]    = '{0, 63, 0, 19};
   int receiver_stall_pct [4] = '{0, 0, 63, 19};

   // decoder shadow state
   logic [COUNT_W-1:0]  len_counts [0:16];
   logic [SYMBOL_W-1:0] sym_mem [0:255];
   logic [CODE_W-1:0]   code_acc;
   logic [CODE_W-1:0]   first_code;
   logic [11:0]         first_index;
   logic [4:0]          code_length;
   logic [LENGTH_W-1:0] frame_left;
   result_type          expected_syms [$];

   // stimulus generation state
   huff_beat_t pending_beats [$];
   int         gen_phase = 0;
   bit         gen_hold = 1'b0;
   int         tbl_count [0:16];
   int         tbl_first_code [1:16];
   int         tbl_first_index [1:16];
   int         tbl_size;
   int         data_beats = 0;
   bit         table_stale = 1'b1;

   huff_beat_t offered;
   int         cur_phase = 0;
   bit         hold_kick = 1'b0;
   int         hold_left = 0;
   int         mismatches = 0;

   function automatic void clear_code();
      code_acc    = '0;
      first_code  = '0;
      first_index = '0;
      code_length = 5'd1;
   endfunction

   function automatic result_type make_result(logic [SYMBOL_W-1:0] sym, logic done, logic err);
      result_type r;
      r.symbol     = sym;
      r.last       = 1'b0;
      r.frame_done = done;
      r.code_error = err;
      return r;
   endfunction

   task automatic decode_beat(input huff_beat_t b);
      result_type          outs [$];
      logic [COUNT_W-1:0]  cnt;
      logic [CODE_W-1:0]   diff;
      logic [7:0]          idx;
      bit                  stopped;
      stopped = 1'b0;
      case (b.act)
         ACT_START: begin
            frame_left = b.flen;
            clear_code();
         end
         ACT_COUNT: begin
            if (b.tidx <= 16) len_counts[b.tidx] = b.bval;
         end
         ACT_SYMBOL: begin
            sym_mem[b.tidx] = b.bval;
         end
         default: begin
            if (frame_left != 0 && len_counts[0] != 0) begin
               frame_left = frame_left - 1'b1;
               outs.push_back(make_result(b.bval, frame_left == 0, 1'b0));
            end else if (frame_left != 0) begin
               for (int i = 0; i < BYTE_BITS; i++) begin
                  if (!stopped) begin
                     cnt        = (code_length <= 16) ? len_counts[code_length] : '0;
                     code_acc   = {code_acc[CODE_W-2:0], b.bval[i]};
                     first_code = {first_code[CODE_W-2:0], 1'b0};
                     diff       = code_acc - first_code;
                     if (code_acc >= first_code && diff < {8'h00, cnt}) begin
                        idx        = diff[7:0] + first_index[7:0];
                        frame_left = frame_left - 1'b1;
                        outs.push_back(make_result(sym_mem[idx], frame_left == 0, 1'b0));
                        clear_code();
                        // rest of the byte is dropped once the frame is complete
                        if (frame_left == 0) stopped = 1'b1;
                     end else begin
                        first_code  = first_code + cnt;
                        first_index = first_index + cnt;
                        code_length = code_length + 1'b1;
                        if (code_length > 16) begin
                           outs.push_back(make_result('0, 1'b0, 1'b1));
                           clear_code();
                        end
                     end
                  end
               end
            end
         end
      endcase
      if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[k]) expected_syms.push_back(outs[k]);
   endtask

   function automatic void queue_beat(action_type a, int ti, int bv, int fl);
      huff_beat_t b;
      b.act   = a;
      b.tidx  = ti[INDEX_W-1:0];
      b.bval  = bv[SYMBOL_W-1:0];
      b.flen  = fl[LENGTH_W-1:0];
      b.phase = gen_phase;
      b.hold  = gen_hold;
      gen_hold = 1'b0;
      if (a == ACT_DATA) data_beats++;
      pending_beats.push_back(b);
   endfunction

   // Random prefix code, complete or missing one leaf at its longest length.
   function automatic void build_code_table();
      int top;
      int avail;
      int keep;
      top = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      avail = 2;
      tbl_size = 0;
      for (int l = 1; l <= 16; l++) begin
         if (l < top) begin
            keep = $urandom_range(1, 2);
            tbl_count[l] = avail - keep;
            avail = 2 * keep;
         end else if (l == top) begin
            tbl_count[l] = ($urandom_range(0, 3) == 0) ? avail - 1 : avail;
         end else begin
            tbl_count[l] = 0;
         end
         tbl_first_index[l] = tbl_size;
         tbl_first_code[l]  = (l == 1) ? 0 : 2 * (tbl_first_code[l-1] + tbl_count[l-1]);
         tbl_size += tbl_count[l];
      end
      queue_beat(ACT_COUNT, 0, 0, $urandom_range(0, 65535));
      for (int l = 1; l <= 16; l++)
         queue_beat(ACT_COUNT, l, tbl_count[l], $urandom_range(0, 65535));
      if ($urandom_range(0, 2) == 0) begin
         for (int s = 0; s < tbl_size; s++)
            queue_beat(ACT_SYMBOL, s, $urandom_range(0, 255), $urandom_range(0, 65535));
      end
      table_stale = 1'b0;
   endfunction

   function automatic void queue_coded_frame(int nsym);
      bit         stream [$];
      int         k;
      int         l;
      int         code;
      int         flen;
      int         nbytes;
      int         bad_byte;
      logic [7:0] b;
      for (int s = 0; s < nsym; s++) begin
         k = $urandom_range(0, tbl_size - 1);
         l = 1;
         while (k >= tbl_first_index[l] + tbl_count[l]) l++;
         code = tbl_first_code[l] + k - tbl_first_index[l];
         for (int j = l - 1; j >= 0; j--) stream.push_back(code[j]);
      end
      case ($urandom_range(0, 7))
         0:       flen = nsym + $urandom_range(1, 3);
         1:       flen = (nsym > 1) ? nsym - 1 : nsym;
         default: flen = nsym;
      endcase
      queue_beat(ACT_START, $urandom_range(0, 255), $urandom_range(0, 255), flen);
      nbytes = (stream.size() + 7) / 8;
      bad_byte = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nbytes - 1) : -1;
      for (int n = 0; n < nbytes; n++) begin
         for (int i = 0; i < 8; i++)
            b[i] = (stream.size() != 0) ? stream.pop_front() : 1'($urandom_range(0, 1));
         if (n == bad_byte) b[$urandom_range(0, 7)] ^= 1'b1;
         queue_beat(ACT_DATA, $urandom_range(0, 255), b, $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 3) == 0)
         queue_beat(ACT_DATA, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 65535));
   endfunction

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected sym %h last %b done %b err %b, got sym %h last %b done %b err %b",
                  what, want.symbol, want.last, want.frame_done, want.code_error,
                  got.symbol, got.last, got.frame_done, got.code_error);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         hold_kick    <= 1'b0;
      end else begin
         hold_kick <= req_ch.valid && req_ch.ready && offered.hold;
         if (req_ch.valid && req_ch.ready) decode_beat(offered);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_beats.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct[pending_beats[0].phase]) begin
               offered = pending_beats.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.action       <= offered.act;
               req_ch.table_index  <= offered.tidx;
               req_ch.byte_value   <= offered.bval;
               req_ch.frame_length <= offered.flen;
               cur_phase           <= offered.phase;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the core backs up into its input
   always @(posedge clock) begin
      if (hold_kick) hold_left <= 400;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // response monitor
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.symbol, rsp_ch.last, rsp_ch.frame_done, rsp_ch.code_error};
            if (expected_syms.size() == 0) begin
               report_mismatch("unexpected beat", '0, got);
            end else begin
               want = expected_syms.pop_front();
               if (got !== want) report_mismatch("mismatch", want, got);
            end
         end
         rsp_ch.ready <= (hold_left == 0) &&
                         ($urandom_range(0, 99) >= receiver_stall_pct[cur_phase]);
      end
   end

   initial begin
      int pick;
      int n;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_START;
      req_ch.table_index  = '0;
      req_ch.byte_value   = '0;
      req_ch.frame_length = '0;
      rsp_ch.ready        = 1'b0;
      offered             = '{ACT_START, '0, '0, '0, 0, 1'b0};
      foreach (len_counts[i]) len_counts[i] = '0;
      foreach (sym_mem[i]) sym_mem[i] = '0;
      clear_code();
      frame_left = '0;

      // whole symbol memory first, so no decode reads an unwritten entry
      for (int s = 0; s < 256; s++)
         queue_beat(ACT_SYMBOL, s, (s == 0) ? 255 : (s == 255) ? 0 : $urandom_range(0, 255), 0);

      queue_beat(ACT_DATA, 0, 8'hFF, 0);               // no frame active
      queue_beat(ACT_COUNT, 1, 2, 0);                  // two 1-bit codes
      queue_beat(ACT_START, 0, 0, 0);                  // zero-length frame
      queue_beat(ACT_DATA, 0, 8'h55, 0);
      queue_beat(ACT_START, 0, 0, 3);                  // frame ends mid byte
      queue_beat(ACT_DATA, 0, 8'hA5, 0);
      queue_beat(ACT_START, 255, 255, 65535);
      queue_beat(ACT_DATA, 255, 8'hFF, 65535);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_COUNT, 17, 9, 0);                 // count index out of range
      queue_beat(ACT_COUNT, 255, 1, 0);
      queue_beat(ACT_COUNT, 1, 0, 0);                  // empty table: code too long
      queue_beat(ACT_START, 0, 0, 3);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_DATA, 0, 8'hFF, 0);
      queue_beat(ACT_COUNT, 16, 255, 0);               // 16-bit codes, full count
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_DATA, 0, 8'hFF, 0);
      queue_beat(ACT_DATA, 0, 8'hFF, 0);
      queue_beat(ACT_DATA, 0, 8'h00, 0);               // partial code, then restart
      queue_beat(ACT_START, 0, 0, 2);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_COUNT, 0, 255, 0);                // raw copy mode
      queue_beat(ACT_START, 0, 0, 2);
      queue_beat(ACT_DATA, 0, 8'h00, 0);
      queue_beat(ACT_DATA, 0, 8'hFF, 0);
      queue_beat(ACT_DATA, 0, 8'h12, 0);
      queue_beat(ACT_COUNT, 0, 0, 0);

      data_beats = 0;
      for (int r = 0; data_beats < 100; r++) begin
         gen_phase = r % 4;
         pick = $urandom_range(0, 9);
         if (r == 5) begin
            gen_phase = 0;
            gen_hold  = 1'b1;
            build_code_table();
            queue_coded_frame(40);
         end else if (pick == 0) begin
            queue_beat(ACT_COUNT, 0, $urandom_range(1, 255), $urandom_range(0, 65535));
            n = $urandom_range(1, 10);
            queue_beat(ACT_START, $urandom_range(0, 255), $urandom_range(0, 255), n);
            repeat (n + $urandom_range(0, 1))
               queue_beat(ACT_DATA, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 65535));
            queue_beat(ACT_COUNT, 0, 0, $urandom_range(0, 65535));
         end else if (pick == 1) begin
            repeat ($urandom_range(3, 8))
               queue_beat(action_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 65535));
            table_stale = 1'b1;
         end else begin
            if (table_stale || $urandom_range(0, 1) == 0) build_code_table();
            queue_coded_frame($urandom_range(1, 12));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sample on the falling edge so driver updates have settled
      @(negedge clock);
      while (pending_beats.size() != 0 || req_ch.valid) @(negedge clock);
      while (expected_syms.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);

      if (mismatches == 0 && expected_syms.size() == 0) begin
         $display("canonical_huffman_decoder_core_tb: done, clean");
      end else begin
         $display("canonical_huffman_decoder_core_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("canonical_huffman_decoder_core_tb: done, errors");
      $finish;
   end

endmodule
